/* sv/smp_pkg.sv */
// Package with types, codes and defaults for the sparse matrix power sum unit.
`default_nettype none
package smp_pkg;

    localparam int MaxStatesDefault   = 256;
    localparam int MaxNonzerosDefault = 4096;
    localparam int StepBitsDefault    = 16;

    localparam logic [1:0] CMD_LOAD_NZ  = 2'd0;
    localparam logic [1:0] CMD_LOAD_VEC = 2'd1;
    localparam logic [1:0] CMD_RUN      = 2'd2;
    localparam logic [1:0] CMD_READ     = 2'd3;

    localparam logic REG_ROW_FORM = 1'b0;
    localparam logic REG_STATES   = 1'b1;

    localparam logic [8:0] STATES_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  row_index;
        logic [7:0]  col_index;
        logic [31:0] value;
        logic [15:0] steps;
    } t_in;

    typedef struct packed {
        logic [7:0]  element_index;
        logic [62:0] total_value;
    } t_out;

    // One stored matrix nonzero.
    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] val;
    } t_nz;

    typedef struct packed {
        t_in  item;
        logic in_range;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage
`default_nettype wire

/* sv/smp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smp_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* sv/smp_front.sv */
// Front end: accepts items, drops ones with no effect, and queues the rest.
`default_nettype none
module smp_front #(
    parameter int MAX_STATES = smp_pkg::MaxStatesDefault,
    parameter int STEP_BITS  = smp_pkg::StepBitsDefault
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire smp_pkg::t_in  i_item,
    input  wire logic          i_pop,
    output smp_pkg::t_head     o_head
);
    smp_pkg::t_job r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       row_ok, col_ok, keep, push;
    smp_pkg::t_job job;

    always_comb begin
        row_ok = 32'(i_item.row_index) < MAX_STATES;
        col_ok = 32'(i_item.col_index) < MAX_STATES;
        case (i_item.command)
            smp_pkg::CMD_LOAD_NZ:  keep = row_ok && col_ok;
            smp_pkg::CMD_LOAD_VEC: keep = row_ok;
            smp_pkg::CMD_RUN:      keep = STEP_BITS'(i_item.steps) != '0;
            default:               keep = 1'b1;
        endcase
        job.item     = i_item;
        job.in_range = row_ok;
    end

    assign busy        = r_cnt == 2'd2;
    assign push        = start && !busy && keep;
    assign o_head.valid = r_cnt != 2'd0;
    assign o_head.job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !push) else $error("push into full queue");
`endif
endmodule
`default_nettype wire

/* sv/smp_back.sv */
// Back end: executes queued items against the matrix, vector and total stores.
`default_nettype none
module smp_back #(
    parameter int MAX_STATES   = smp_pkg::MaxStatesDefault,
    parameter int MAX_NONZEROS = smp_pkg::MaxNonzerosDefault,
    parameter int STEP_BITS    = smp_pkg::StepBitsDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire smp_pkg::t_head i_head,
    output logic                o_pop,
    input  wire logic           i_row_form,
    input  wire logic [8:0]     i_states,
    output logic                o_done,
    output smp_pkg::t_out       o_result
);
    localparam int SW = $clog2(MAX_STATES);
    localparam int UW = $clog2(MAX_STATES + 1);
    localparam int NW = $clog2(MAX_NONZEROS);
    localparam int CW = $clog2(MAX_NONZEROS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RWAIT, S_CLR, S_MRD, S_M, S_V, S_A, S_FR, S_FW
    } t_state;

    t_state r_st;
    logic [CW-1:0]         r_cnt, r_k;
    logic [SW-1:0]         r_i, r_dst;
    logic [STEP_BITS-1:0]  r_steps;
    logic [UW-1:0]         r_used;
    logic                  r_bank;
    logic [MAX_STATES-1:0] r_acc_vld;
    logic [31:0]           r_val;
    logic [32:0]           r_prod, r_accold;

    // Store ports.
    logic            mat_we, mat_re;
    logic [NW-1:0]   mat_waddr, mat_raddr;
    smp_pkg::t_nz    mat_wdata, mat_rdata;
    logic            vec_we, vec_re;
    logic [SW:0]     vec_waddr, vec_raddr;
    logic [31:0]     vec_wdata, vec_rdata;
    logic            acc_we, acc_re;
    logic [SW-1:0]   acc_waddr, acc_raddr;
    logic [32:0]     acc_wdata, acc_rdata;
    logic            tot_we, tot_re;
    logic [SW-1:0]   tot_waddr, tot_raddr;
    logic [62:0]     tot_wdata, tot_rdata;

    smp_pkg::t_in  it;
    logic [7:0]    src, dst;
    logic          pass, last_k, in_use;
    logic [33:0]   asum;
    logic [32:0]   acc_cur;
    logic [31:0]   nv;
    logic [63:0]   tsum;
    logic [UW-1:0] used_new;

    smp_ram #(.W(48), .D(MAX_NONZEROS)) u_mat (
        .i_clk, .i_we(mat_we), .i_waddr(mat_waddr), .i_wdata(mat_wdata),
        .i_re(mat_re), .i_raddr(mat_raddr), .o_rdata(mat_rdata));
    smp_ram #(.W(32), .D(2 * MAX_STATES)) u_vec (
        .i_clk, .i_we(vec_we), .i_waddr(vec_waddr), .i_wdata(vec_wdata),
        .i_re(vec_re), .i_raddr(vec_raddr), .o_rdata(vec_rdata));
    smp_ram #(.W(33), .D(MAX_STATES)) u_acc (
        .i_clk, .i_we(acc_we), .i_waddr(acc_waddr), .i_wdata(acc_wdata),
        .i_re(acc_re), .i_raddr(acc_raddr), .o_rdata(acc_rdata));
    smp_ram #(.W(63), .D(MAX_STATES)) u_tot (
        .i_clk, .i_we(tot_we), .i_waddr(tot_waddr), .i_wdata(tot_wdata),
        .i_re(tot_re), .i_raddr(tot_raddr), .o_rdata(tot_rdata));

    always_comb begin
        it       = i_head.job.item;
        o_pop    = (r_st == S_IDLE) && i_head.valid;
        used_new = (32'(i_states) < MAX_STATES) ? UW'(i_states) : UW'(MAX_STATES);
        src      = i_row_form ? mat_rdata.row : mat_rdata.col;
        dst      = i_row_form ? mat_rdata.col : mat_rdata.row;
        pass     = (32'(mat_rdata.row) < 32'(r_used)) && (32'(mat_rdata.col) < 32'(r_used));
        last_k   = (r_k + CW'(1)) == r_cnt;
        // Per-element accumulators saturate on overflow instead of wrapping.
        asum     = {1'b0, r_accold} + {1'b0, r_prod};
        in_use   = 32'(r_i) < 32'(r_used);
        acc_cur  = r_acc_vld[r_i] ? acc_rdata : 33'd0;
        nv       = !in_use ? 32'd0 : (acc_cur[32] ? 32'hFFFF_FFFF : acc_cur[31:0]);
        tsum     = {1'b0, tot_rdata} + 64'(nv);

        mat_we = 1'b0; mat_waddr = r_cnt[NW-1:0];
        mat_wdata = '{row: it.row_index, col: it.col_index, val: it.value};
        mat_re = 1'b0; mat_raddr = r_k[NW-1:0];
        vec_we = 1'b0; vec_waddr = {r_bank, SW'(it.row_index)}; vec_wdata = it.value;
        vec_re = 1'b0; vec_raddr = {r_bank, SW'(src)};
        acc_we = 1'b0; acc_waddr = r_dst; acc_wdata = asum[33] ? '1 : asum[32:0];
        acc_re = 1'b0; acc_raddr = SW'(dst);
        tot_we = 1'b0; tot_waddr = SW'(it.row_index); tot_wdata = 63'(it.value);
        tot_re = 1'b0; tot_raddr = SW'(it.row_index);

        unique case (r_st)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (it.command)
                        smp_pkg::CMD_LOAD_NZ:  mat_we = 32'(r_cnt) < MAX_NONZEROS;
                        smp_pkg::CMD_LOAD_VEC: begin
                            vec_we = 1'b1;
                            tot_we = 1'b1;
                        end
                        smp_pkg::CMD_READ:     tot_re = i_head.job.in_range;
                        default: ;
                    endcase
                end
            end
            S_MRD: mat_re = 1'b1;
            S_M: begin
                vec_re = pass;
                acc_re = pass;
            end
            S_A: acc_we = 1'b1;
            S_FR: begin
                acc_re    = 1'b1;
                acc_raddr = r_i;
                tot_re    = 1'b1;
                tot_raddr = r_i;
            end
            S_FW: begin
                vec_we    = 1'b1;
                vec_waddr = {~r_bank, r_i};
                vec_wdata = nv;
                tot_we    = in_use;
                tot_waddr = r_i;
                tot_wdata = tsum[63] ? '1 : tsum[62:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_cnt  <= '0;
            r_bank <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_head.valid) begin
                        unique case (it.command)
                            smp_pkg::CMD_LOAD_NZ: begin
                                if (32'(r_cnt) < MAX_NONZEROS) begin
                                    r_cnt <= r_cnt + CW'(1);
                                end
                            end
                            smp_pkg::CMD_RUN: begin
                                r_steps <= STEP_BITS'(it.steps);
                                r_used  <= used_new;
                                r_st    <= S_CLR;
                            end
                            smp_pkg::CMD_READ: begin
                                o_result.element_index <= it.row_index;
                                if (i_head.job.in_range) begin
                                    r_st <= S_RWAIT;
                                end else begin
                                    o_result.total_value <= '0;
                                    o_done <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RWAIT: begin
                    o_result.total_value <= tot_rdata;
                    o_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                S_CLR: begin
                    r_acc_vld <= '0;
                    r_k <= '0;
                    r_i <= '0;
                    r_st <= (r_cnt == '0) ? S_FR : S_MRD;
                end
                S_MRD: r_st <= S_M;
                S_M: begin
                    r_dst <= SW'(dst);
                    r_val <= mat_rdata.val;
                    if (pass) begin
                        r_st <= S_V;
                    end else begin
                        r_k  <= r_k + CW'(1);
                        r_st <= last_k ? S_FR : S_MRD;
                    end
                end
                S_V: begin
                    r_prod   <= 33'((64'(r_val) * 64'(vec_rdata)) >> 31);
                    r_accold <= r_acc_vld[r_dst] ? acc_rdata : 33'd0;
                    r_st     <= S_A;
                end
                S_A: begin
                    r_acc_vld[r_dst] <= 1'b1;
                    r_k  <= r_k + CW'(1);
                    r_st <= last_k ? S_FR : S_MRD;
                end
                S_FR: r_st <= S_FW;
                S_FW: begin
                    if (32'(r_i) == MAX_STATES - 1) begin
                        r_bank  <= ~r_bank;
                        r_steps <= r_steps - STEP_BITS'(1);
                        r_st    <= (r_steps == STEP_BITS'(1)) ? S_IDLE : S_CLR;
                    end else begin
                        r_i  <= r_i + SW'(1);
                        r_st <= S_FR;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_NONZEROS) else $error("entry count overflow");
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_st == S_RWAIT || r_st == S_IDLE))
        else $error("result outside read path");
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_bank != $past(r_bank) |-> $past(r_st == S_FW))
        else $error("bank switched outside step end");
`endif
endmodule
`default_nettype wire

/* sv/sparse_matrix_power_sum_unit.sv */
// Top level of the sparse matrix power sum unit.
//   channel   direction  signals                       handshake
//   command   in         i_item (t_in)                 start && !busy
//   result    out        o_result (t_out)              o_done, one cycle
//   config    in         i_cfg_idx, i_cfg_data         i_cfg_we
// Items pass through a two-item queue ahead of the back end.
// A run, per step, reads every stored nonzero, accumulates those inside the used range,
// then sweeps all MAX_STATES elements to update the vector and the totals.
// Reset is synchronous and active low; the stores need no clearing pass.
// busy rises only when the queue is full; results cannot be held off.
`default_nettype none
module sparse_matrix_power_sum_unit #(
    parameter int MAX_STATES   = smp_pkg::MaxStatesDefault,
    parameter int MAX_NONZEROS = smp_pkg::MaxNonzerosDefault,
    parameter int STEP_BITS    = smp_pkg::StepBitsDefault
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire smp_pkg::t_in  i_item,
    output logic               o_done,
    output smp_pkg::t_out      o_result,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [8:0]    i_cfg_data
);
    logic           r_row_form;
    logic [8:0]     r_states;
    smp_pkg::t_head head;
    logic           pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_form <= 1'b0;
            r_states   <= smp_pkg::STATES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smp_pkg::REG_ROW_FORM: r_row_form <= i_cfg_data[0];
                default:               r_states   <= i_cfg_data;
            endcase
        end
    end

    smp_front #(.MAX_STATES(MAX_STATES), .STEP_BITS(STEP_BITS)) u_front (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .i_pop(pop), .o_head(head));

    smp_back #(.MAX_STATES(MAX_STATES), .MAX_NONZEROS(MAX_NONZEROS),
               .STEP_BITS(STEP_BITS)) u_back (
        .i_clk, .i_rst_n, .i_head(head), .o_pop(pop), .i_row_form(r_row_form),
        .i_states(r_states), .o_done, .o_result);
endmodule
`default_nettype wire

/* verif/smp_checker.sv */
// Checker for the sparse matrix power sum unit: predicts read totals and compares results.
module smp_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  smp_pkg::t_in            i_item,
    input  logic                    i_done,
    input  smp_pkg::t_out           i_result,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [8:0]              i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);
    localparam int NumStates = smp_pkg::MaxStatesDefault;
    localparam int NumNz     = smp_pkg::MaxNonzerosDefault;
    localparam logic [62:0] TotalMax = {63{1'b1}};

    logic [7:0]    nz_row [NumNz];
    logic [7:0]    nz_col [NumNz];
    logic [31:0]   nz_val [NumNz];
    int            nz_count;
    logic [31:0]   chain_vec [2][NumStates];
    bit            cur_bank;
    logic [62:0]   visit_total [NumStates];
    bit            row_form;
    int            states_used;
    smp_pkg::t_out totals_due [$];

    initial o_errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        o_errors++;
    endtask

    // One power step: next vector from the current one, then fold it into the totals.
    task automatic advance_chain(input int used);
        logic [63:0] acc [NumStates];
        logic [63:0] prod;
        logic [63:0] sum;
        logic [31:0] elem;
        int src;
        int dst;
        for (int i = 0; i < NumStates; i++) acc[i] = '0;
        for (int k = 0; k < nz_count; k++) begin
            if (int'(nz_row[k]) < used && int'(nz_col[k]) < used) begin
                src = row_form ? int'(nz_row[k]) : int'(nz_col[k]);
                dst = row_form ? int'(nz_col[k]) : int'(nz_row[k]);
                prod = {32'b0, nz_val[k]} * {32'b0, chain_vec[cur_bank][src]};
                acc[dst] += prod >> 31;
            end
        end
        for (int i = 0; i < NumStates; i++) begin
            if (i < used) begin
                elem = (acc[i] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[i][31:0];
                chain_vec[!cur_bank][i] = elem;
                sum = {1'b0, visit_total[i]} + {32'b0, elem};
                visit_total[i] = (sum > {1'b0, TotalMax}) ? TotalMax : sum[62:0];
            end else begin
                chain_vec[!cur_bank][i] = '0;
            end
        end
        cur_bank = !cur_bank;
    endtask

    always @(posedge i_clk) begin
        smp_pkg::t_out want;
        int used;
        if (!i_rst_n) begin
            nz_count = 0;
            cur_bank = 0;
            row_form = 0;
            states_used = 256;
            totals_due.delete();
        end else begin
            if (i_done) begin
                if (totals_due.size() == 0) begin
                    report($sformatf("unexpected result index %0d",
                                     i_result.element_index));
                end else begin
                    want = totals_due.pop_front();
                    if (i_result.element_index !== want.element_index)
                        report($sformatf("element_index %0d, expected %0d",
                                         i_result.element_index, want.element_index));
                    if (i_result.total_value !== want.total_value)
                        report($sformatf("total_value %h, expected %h for index %0d",
                                         i_result.total_value, want.total_value,
                                         want.element_index));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == smp_pkg::REG_ROW_FORM) row_form = i_cfg_data[0];
                else states_used = int'(i_cfg_data);
            end
            if (start && !busy) begin
                case (i_item.command)
                    smp_pkg::CMD_LOAD_NZ: begin
                        if (nz_count < NumNz) begin
                            nz_row[nz_count] = i_item.row_index;
                            nz_col[nz_count] = i_item.col_index;
                            nz_val[nz_count] = i_item.value;
                            nz_count++;
                        end
                    end
                    smp_pkg::CMD_LOAD_VEC: begin
                        chain_vec[cur_bank][i_item.row_index] = i_item.value;
                        visit_total[i_item.row_index] = {31'b0, i_item.value};
                    end
                    smp_pkg::CMD_RUN: begin
                        used = (states_used < NumStates) ? states_used : NumStates;
                        for (int s = 0; s < int'(i_item.steps); s++) advance_chain(used);
                    end
                    default: begin
                        want.element_index = i_item.row_index;
                        want.total_value = visit_total[i_item.row_index];
                        totals_due.push_back(want);
                    end
                endcase
            end
        end
        o_pending = totals_due.size();
    end

endmodule

/* verif/tb_sparse_matrix_power_sum_unit.sv */
// Testbench top for the sparse matrix power sum unit: clock, reset, stimulus and verdict.
module tb_sparse_matrix_power_sum_unit;

    localparam int CycleLimit = 500000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    smp_pkg::t_in  cmd_item;
    logic          o_done;
    smp_pkg::t_out o_result;
    logic          i_cfg_we;
    logic          i_cfg_idx;
    logic [8:0]    i_cfg_data;
    int            errors;
    int            pending;
    int            cycles;
    bit            idle_on;
    bit            loaded [256];
    int            used_now;

    sparse_matrix_power_sum_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(cmd_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    smp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(cmd_item), .i_done(o_done), .i_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Send one item as given, after a random idle gap when enabled, and hold it while busy.
    task automatic send(input logic [1:0] cmd, input logic [7:0] row, input logic [7:0] col,
                        input logic [31:0] val, input logic [15:0] steps);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            start = 0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        start = 1;
        cmd_item.command = cmd;
        cmd_item.row_index = row;
        cmd_item.col_index = col;
        cmd_item.value = val;
        cmd_item.steps = steps;
        do @(posedge i_clk); while (busy);
        if (cmd == smp_pkg::CMD_LOAD_VEC) loaded[row] = 1;
    endtask

    task automatic read_loaded();
        int idx;
        do idx = $urandom_range(0, 255); while (!loaded[idx]);
        send(smp_pkg::CMD_READ, idx[7:0], 8'($urandom), $urandom, 16'($urandom));
    endtask

    // A read queues behind earlier work, so its return means the block is drained.
    task automatic drain();
        read_loaded();
        @(negedge i_clk);
        start = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        if (idx == smp_pkg::REG_STATES) used_now = (data > 9'd256) ? 256 : int'(data);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic random_items(input int count);
        int missing;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:
                    send(smp_pkg::CMD_LOAD_NZ, 8'($urandom_range(0, used_now + 3)),
                         8'($urandom_range(0, used_now + 3)), pick_value(), 16'($urandom));
                7, 8, 9, 10, 11:
                    send(smp_pkg::CMD_LOAD_VEC, 8'($urandom), 8'($urandom), pick_value(),
                         16'($urandom));
                12, 13, 14: begin
                    // Every total in use must hold a value before a run.
                    missing = -1;
                    for (int i = used_now - 1; i >= 0; i--) if (!loaded[i]) missing = i;
                    if (missing >= 0)
                        send(smp_pkg::CMD_LOAD_VEC, missing[7:0], 8'($urandom), pick_value(),
                             16'($urandom));
                    else
                        send(smp_pkg::CMD_RUN, 8'($urandom), 8'($urandom), $urandom,
                             16'($urandom_range(0, 3)));
                end
                default: read_loaded();
            endcase
        end
    endtask

    initial begin
        i_rst_n = 0;
        start = 0;
        cmd_item = '0;
        i_cfg_we = 0;
        i_cfg_idx = smp_pkg::REG_ROW_FORM;
        i_cfg_data = '0;
        idle_on = 1;
        used_now = 256;
        for (int i = 0; i < 256; i++) loaded[i] = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        write_reg(smp_pkg::REG_ROW_FORM, 1'b0);
        write_reg(smp_pkg::REG_STATES, 9'd4);
        send(smp_pkg::CMD_LOAD_VEC, 8'd0, 8'hFF, 32'h0, 16'hFFFF);
        send(smp_pkg::CMD_LOAD_VEC, 8'd1, 8'h00, 32'h8000_0000, 16'h0000);
        send(smp_pkg::CMD_LOAD_VEC, 8'd2, 8'hA5, 32'hFFFF_FFFF, 16'h5A5A);
        send(smp_pkg::CMD_LOAD_VEC, 8'd3, 8'h5A, 32'h7FFF_FFFF, 16'hA5A5);
        send(smp_pkg::CMD_LOAD_NZ, 8'd0, 8'd1, 32'h8000_0000, 16'hFFFF);
        // The duplicates add, and with a full vector element they saturate it.
        send(smp_pkg::CMD_LOAD_NZ, 8'd1, 8'd2, 32'hFFFF_FFFF, 16'h0);
        send(smp_pkg::CMD_LOAD_NZ, 8'd1, 8'd2, 32'hFFFF_FFFF, 16'h1234);
        send(smp_pkg::CMD_LOAD_NZ, 8'd2, 8'd3, 32'h4000_0000, 16'h0);
        send(smp_pkg::CMD_LOAD_NZ, 8'd3, 8'd200, 32'h8000_0000, 16'h0);
        send(smp_pkg::CMD_LOAD_NZ, 8'd255, 8'd0, 32'h8000_0000, 16'h0);
        send(smp_pkg::CMD_LOAD_NZ, 8'd3, 8'd3, 32'h0, 16'h0);
        send(smp_pkg::CMD_READ, 8'd2, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send(smp_pkg::CMD_RUN, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'd0);
        send(smp_pkg::CMD_READ, 8'd1, 8'h0, 32'h0, 16'h0);
        send(smp_pkg::CMD_RUN, 8'h0, 8'h0, 32'h0, 16'd1);
        for (int i = 0; i < 4; i++) send(smp_pkg::CMD_READ, i[7:0], 8'h0, 32'h0, 16'h0);
        send(smp_pkg::CMD_RUN, 8'h0, 8'h0, 32'h0, 16'd3);
        send(smp_pkg::CMD_READ, 8'd1, 8'h0, 32'h0, 16'h0);
        send(smp_pkg::CMD_READ, 8'd2, 8'h0, 32'h0, 16'h0);
        drain();

        write_reg(smp_pkg::REG_ROW_FORM, 1'b1);
        write_reg(smp_pkg::REG_STATES, 9'd1);
        random_items(35);
        drain();

        write_reg(smp_pkg::REG_ROW_FORM, 1'b0);
        write_reg(smp_pkg::REG_STATES, 9'd12);
        random_items(40);
        drain();

        idle_on = 0;
        write_reg(smp_pkg::REG_ROW_FORM, 1'b1);
        write_reg(smp_pkg::REG_STATES, 9'd7);
        random_items(40);
        drain();

        // With no element in use a run leaves every total as it was.
        write_reg(smp_pkg::REG_STATES, 9'd0);
        send(smp_pkg::CMD_RUN, 8'h0, 8'h0, 32'h0, 16'd2);
        read_loaded();
        @(negedge i_clk);
        start = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
sv/smp_pkg.sv
sv/smp_ram.sv
sv/smp_front.sv
sv/smp_back.sv
sv/sparse_matrix_power_sum_unit.sv
verif/smp_checker.sv
verif/tb_sparse_matrix_power_sum_unit.sv
